@@ rtl/websocket_frame_deframer_defines.svh @@
// Assertion macros used by the checker file wsfd_checker.sv.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("websocket deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("websocket deframer check failed");

`endif

@@ rtl/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam logic [1:0] EvByte  = 2'd0;
  localparam logic [1:0] EvEmpty = 2'd1;
  localparam logic [1:0] EvClose = 2'd2;

  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  localparam logic [2:0] Ext16Last = 3'd1;
  localparam logic [2:0] Ext64Last = 3'd7;
  localparam logic [2:0] MaskLast  = 3'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       eom;
    logic [3:0] opcode;
  } wsfd_res_t;

endpackage

@@ rtl/wsfd_parser.sv @@
module wsfd_parser import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  output wsfd_res_t  res_o
);

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExt16   = 3'd2,
    PhExt64   = 3'd3,
    PhMask    = 3'd4,
    PhPayload = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  off_q, off_d;

  logic        after_len;
  logic        hdr_done;
  logic        last;
  logic [7:0]  key_byte;
  logic [2:0]  ext_last;

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    off_d     = off_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    last      = 1'b0;
    key_byte  = 8'd0;
    ext_last  = (phase_q == PhExt16) ? Ext16Last : Ext64Last;
    res_o     = '0;
    res_o.opcode = opcode_q;

    case (phase_q)
      PhHdr1: begin
        mask_d = rx_byte_i[7];
        key_d  = '0;
        cnt_d  = '0;
        len_d  = '0;
        if (rx_byte_i[6:0] == Len7Ext16) begin
          phase_d = PhExt16;
        end else if (rx_byte_i[6:0] == Len7Ext64) begin
          phase_d = PhExt64;
        end else begin
          len_d     = {57'd0, rx_byte_i[6:0]};
          after_len = 1'b1;
        end
      end
      PhExt16, PhExt64: begin
        len_d = {len_q[55:0], rx_byte_i};
        if (cnt_q >= ext_last) begin
          after_len = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhMask: begin
        key_d = {key_q[23:0], rx_byte_i};
        if (cnt_q >= MaskLast) begin
          hdr_done = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhPayload: begin
        if (mask_q) begin
          case (off_q)
            2'd0:    key_byte = key_q[31:24];
            2'd1:    key_byte = key_q[23:16];
            2'd2:    key_byte = key_q[15:8];
            default: key_byte = key_q[7:0];
          endcase
        end
        off_d = off_q + 2'd1;
        len_d = len_q - 64'd1;
        last  = (len_d == 64'd0);
        if (last) begin
          phase_d = PhHdr0;
          off_d   = '0;
        end
        if (opcode_q == OpClose) begin
          if (last) begin
            res_o.valid = 1'b1;
            res_o.kind  = EvClose;
            res_o.eom   = 1'b1;
          end
        end else if (opcode_q != OpPing) begin
          res_o.valid = 1'b1;
          res_o.kind  = EvByte;
          res_o.data  = rx_byte_i ^ key_byte;
          res_o.eom   = last;
        end
      end
      default: begin
        opcode_d = rx_byte_i[3:0];
        phase_d  = PhHdr1;
      end
    endcase

    if (after_len) begin
      cnt_d = '0;
      if (mask_d) begin
        phase_d = PhMask;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      cnt_d   = '0;
      off_d   = '0;
      phase_d = (len_d != 64'd0) ? PhPayload : PhHdr0;
      if (len_d == 64'd0 && opcode_q != OpPing) begin
        res_o.valid = 1'b1;
        res_o.kind  = (opcode_q == OpClose) ? EvClose : EvEmpty;
        res_o.eom   = 1'b1;
      end
    end

    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      off_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      off_q    <= off_d;
    end
  end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket frame deframer, receive side.
// The input channel (in_valid_i, in_stall_o, rx_byte_i) takes one byte of the
// received stream per transaction. The output channel (out_valid_o,
// out_stall_i and the four result ports) carries payload bytes, empty-message
// events and close events; a byte that causes no result produces nothing.
// An accepted byte lands in an input register; when the output register can
// advance, the parser updates its header state and writes any result into
// the output register, so a result passes the input and output registers.
// Throughput is one byte per cycle unless the receiver stalls, held by the
// 64-bit remaining-length decrement and zero compare in the parser payload path.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more byte if it is empty; then in_stall_o
// rises until the output side drains.
// Reset clears both registers and returns the parser to the first header
// byte of a frame with the length, mask key and opcode cleared.
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       end_of_message_o,
  output logic [3:0] frame_opcode_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       step;
  wsfd_res_t  res;
  wsfd_res_t  out_q;

  assign advance    = !out_q.valid || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  wsfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= '0;
      out_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
        if (in_valid_i) begin
          in_byte_q <= rx_byte_i;
        end
      end
      if (advance) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o      = out_q.valid;
  assign event_kind_o     = out_q.kind;
  assign payload_byte_o   = out_q.data;
  assign end_of_message_o = out_q.eom;
  assign frame_opcode_o   = out_q.opcode;

endmodule

@@ rtl/wsfd_checker.sv @@
`include "websocket_frame_deframer_defines.svh"

module wsfd_checker import wsfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_kind_o,
  input logic [7:0] payload_byte_o,
  input logic       end_of_message_o,
  input logic [3:0] frame_opcode_o
);

  `WSFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(event_kind_o) && $stable(payload_byte_o) && $stable(end_of_message_o) && $stable(frame_opcode_o))

  `WSFD_ASSERT_NOW(a_event_form, clk_i, rst_ni, out_valid_o && event_kind_o != EvByte, (event_kind_o == EvEmpty || event_kind_o == EvClose) && payload_byte_o == 8'd0 && end_of_message_o)

  `WSFD_ASSERT_NOW(a_close_opcode, clk_i, rst_ni, out_valid_o && event_kind_o == EvClose, frame_opcode_o == OpClose)

  `WSFD_ASSERT_NOW(a_data_opcode, clk_i, rst_ni, out_valid_o && (event_kind_o == EvByte || event_kind_o == EvEmpty), frame_opcode_o != OpClose && frame_opcode_o != OpPing)

  `WSFD_ASSERT_NEXT(a_stall_cause, clk_i, rst_ni, !out_valid_o || !out_stall_i, !in_stall_o || $past(in_valid_i))

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_kind_o     (event_kind_o),
  .payload_byte_o   (payload_byte_o),
  .end_of_message_o (end_of_message_o),
  .frame_opcode_o   (frame_opcode_o)
);
